// File: design/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg: shared constants and codes of the straight wire field block
// Field widths, register indexes, status codes and divider sizes.
// ----------------------------------------------------------------------------
package swmf_pkg;

	localparam int POS_W      = 32;
	localparam int DIR_W      = 16;
	localparam int GAIN_W     = 48;
	localparam int FIELD_W    = 56;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam int NUM_W = 128;
	localparam int DEN_W = 114;
	localparam int QUO_W = 57;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_ORIGIN_Z    = 3'd2,
		REG_DIRECTION_X = 3'd3,
		REG_DIRECTION_Y = 3'd4,
		REG_DIRECTION_Z = 3'd5,
		REG_FIELD_GAIN  = 3'd6
	} cfg_reg_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_ON_WIRE   = 2'd1,
		ST_SATURATED = 2'd2,
		ST_DIR_ZERO  = 2'd3
	} status_t;

endpackage

// File: design/swmf_if.sv
// ----------------------------------------------------------------------------
// swmf_if: channel interfaces of the straight wire field block
// Query positions, field results and configuration writes.
// ----------------------------------------------------------------------------
interface swmf_pos_if import swmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position_x;
	logic [POS_W-1:0] position_y;
	logic [POS_W-1:0] position_z;

	modport source (output valid, output position_x, output position_y, output position_z,
		input ready);
	modport sink (input valid, input position_x, input position_y, input position_z,
		output ready);
endinterface

interface swmf_fld_if import swmf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] field_x;
	logic [FIELD_W-1:0] field_y;
	logic [FIELD_W-1:0] field_z;
	logic [STAT_W-1:0]  status;

	modport source (output valid, output field_x, output field_y, output field_z,
		output status, input ready);
	modport sink (input valid, input field_x, input field_y, input field_z,
		input status, output ready);
endinterface

interface swmf_cfg_if import swmf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/swmf_div.sv
// ----------------------------------------------------------------------------
// swmf_div: pipelined restoring divider
// One quotient bit per stage; flags quotients that do not fit the stages.
// ----------------------------------------------------------------------------
module swmf_div import swmf_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic [DEN_W-1:0] rem,
	output logic [DEN_W-1:0] den_out,
	output logic             big
);

	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic             big_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_p;
		logic [QUO_W-1:0] quo_p;
		logic [QUO_W-1:0] low_p;
		logic [DEN_W-1:0] den_p;
		logic             big_p;
		logic [DEN_W:0]   trial;
		logic             take;

		if (k == 0) begin : g_first
			assign rem_p = DEN_W'(num[NUM_W-1:QUO_W]);
			assign quo_p = '0;
			assign low_p = num[QUO_W-1:0];
			assign den_p = den;
			assign big_p = DEN_W'(num[NUM_W-1:QUO_W]) >= den;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign quo_p = quo_s[k-1];
			assign low_p = low_s[k-1];
			assign den_p = den_s[k-1];
			assign big_p = big_s[k-1];
		end

		assign trial = {rem_p, low_p[QUO_W-1]};
		assign take  = trial >= {1'b0, den_p};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? DEN_W'(trial - {1'b0, den_p}) : DEN_W'(trial);
				quo_s[k] <= {quo_p[QUO_W-2:0], take};
				low_s[k] <= {low_p[QUO_W-2:0], 1'b0};
				den_s[k] <= den_p;
				big_s[k] <= big_p;
			end
		end
	end

	assign quo     = quo_s[QUO_W-1];
	assign rem     = rem_s[QUO_W-1];
	assign den_out = den_s[QUO_W-1];
	assign big     = big_s[QUO_W-1];

endmodule

// File: design/straight_wire_magnetic_field.sv
// ----------------------------------------------------------------------------
// straight_wire_magnetic_field: field of an infinite straight wire
// Evaluates gain * |d| * (d x OP) / |d x OP|^2 per query point, rounded.
// ----------------------------------------------------------------------------
//  Channel  Role   Beat contents
//  pos      sink   position_x, position_y, position_z (Q16.16 m)
//  field    source field_x, field_y, field_z (2^-40 T), status
//  cfg      sink   register index and write data
//
// A beat enters every cycle unless the output stalls or a cfg write arrives;
// results pass through ten arithmetic stages, a 57-stage divider (one quotient
// bit per stage) and the output register. The square root of |d|^2 runs from
// the configuration in an eight-stage pipeline. Reset clears origin, gain and all
// valid bits and sets the direction to +z. An output stall holds the query stages.
// ----------------------------------------------------------------------------
module straight_wire_magnetic_field import swmf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	swmf_pos_if.sink  pos,
	swmf_fld_if.source field,
	swmf_cfg_if.sink  cfg
);

	localparam int OP_W    = POS_W + 1;
	localparam int DOP_W   = DIR_W + OP_W;
	localparam int C_W     = DOP_W + 1;
	localparam int CMAG_W  = C_W - 1;
	localparam int PROD_W  = 97;
	localparam int CSQ_W   = 98;
	localparam int DD_W    = 32;
	localparam int ROOT_W  = 32;
	localparam int REM_W   = 34;
	localparam int SQ_STG  = 8;
	localparam int SQ_STEP = 4;
	localparam int FRONT   = 10;
	localparam int NSTG    = FRONT + QUO_W + 1;
	localparam int QR_W    = QUO_W + 1;
	localparam logic [QR_W-1:0] MAG_POS_MAX = QR_W'({(FIELD_W-1){1'b1}});
	localparam logic [QR_W-1:0] MAG_NEG_MAX = QR_W'(64'd1 << (FIELD_W-1));

	typedef struct packed {
		logic [2:0][PROD_W-1:0] prod;
		logic [CSQ_W-1:0]       cc;
		logic [2:0]             cneg;
	} hold_t;

	logic [POS_W-1:0]  origin_q [3];
	logic [DIR_W-1:0]  dir_q [3];
	logic [GAIN_W-1:0] gain_q;

	logic            en;
	logic            acc;
	logic [NSTG-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q[0] <= '0;
			origin_q[1] <= '0;
			origin_q[2] <= '0;
			dir_q[0]    <= '0;
			dir_q[1]    <= '0;
			dir_q[2]    <= DIR_W'(1);
			gain_q      <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_ORIGIN_X:    origin_q[0] <= cfg.data[POS_W-1:0];
				REG_ORIGIN_Y:    origin_q[1] <= cfg.data[POS_W-1:0];
				REG_ORIGIN_Z:    origin_q[2] <= cfg.data[POS_W-1:0];
				REG_DIRECTION_X: dir_q[0]    <= cfg.data[DIR_W-1:0];
				REG_DIRECTION_Y: dir_q[1]    <= cfg.data[DIR_W-1:0];
				REG_DIRECTION_Z: dir_q[2]    <= cfg.data[DIR_W-1:0];
				REG_FIELD_GAIN:  gain_q      <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready   = 1'b1;
	assign en          = ~vld_q[NSTG-1] | field.ready;
	assign pos.ready   = en & ~cfg.valid;
	assign acc         = pos.valid & pos.ready;
	assign field.valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], acc};
		end
	end

	logic signed [DIR_W-1:0] d [3];
	logic [DD_W-1:0]         dsq [3];
	logic [DD_W-1:0]         dd_cfg;
	logic [GAIN_W-1:0]       gain_abs;
	logic                    dir_zero;

	for (genvar i = 0; i < 3; i++) begin : g_dir
		assign d[i]   = $signed(dir_q[i]);
		assign dsq[i] = d[i] * d[i];
	end
	assign dd_cfg   = DD_W'(dsq[0] + dsq[1] + dsq[2]);
	assign gain_abs = gain_q[GAIN_W-1] ? GAIN_W'(~gain_q + 1'b1) : gain_q;
	assign dir_zero = (dir_q[0] == '0) && (dir_q[1] == '0) && (dir_q[2] == '0);

	logic [REM_W-1:0]    sq_rem_q [SQ_STG];
	logic [ROOT_W-1:0]   sq_root_q [SQ_STG];
	logic [2*DD_W-1:0]   sq_x_q [SQ_STG];

	for (genvar st = 0; st < SQ_STG; st++) begin : g_sqrt
		logic [REM_W-1:0]  rem_p;
		logic [ROOT_W-1:0] root_p;
		logic [2*DD_W-1:0] x_p;
		logic [REM_W-1:0]  rem_n;
		logic [ROOT_W-1:0] root_n;
		logic [2*DD_W-1:0] x_n;

		if (st == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign x_p    = {dd_cfg, {DD_W{1'b0}}};
		end else begin : g_next
			assign rem_p  = sq_rem_q[st-1];
			assign root_p = sq_root_q[st-1];
			assign x_p    = sq_x_q[st-1];
		end

		always_comb begin
			logic [REM_W+1:0] rem2;
			logic [REM_W+1:0] trial;
			rem_n  = rem_p;
			root_n = root_p;
			x_n    = x_p;
			for (int j = 0; j < SQ_STEP; j++) begin
				rem2  = {rem_n, x_n[2*DD_W-1 -: 2]};
				trial = {2'b00, root_n, 2'b01};
				if (rem2 >= trial) begin
					rem_n  = REM_W'(rem2 - trial);
					root_n = {root_n[ROOT_W-2:0], 1'b1};
				end else begin
					rem_n  = REM_W'(rem2);
					root_n = {root_n[ROOT_W-2:0], 1'b0};
				end
				x_n = {x_n[2*DD_W-3:0], 2'b00};
			end
		end

		always_ff @(posedge clk) begin
			sq_rem_q[st]  <= rem_n;
			sq_root_q[st] <= root_n;
			sq_x_q[st]    <= x_n;
		end
	end

	logic signed [OP_W-1:0]  op_s1 [3];
	logic signed [DOP_W-1:0] dop_s2 [6];
	logic signed [C_W-1:0]   cv [3];
	logic [CMAG_W-1:0]       cmag_s3 [3];
	logic [2:0]              cneg_s3;
	logic [33:0]             sq_hh_s4 [3];
	logic [48:0]             sq_hl_s4 [3];
	logic [63:0]             sq_ll_s4 [3];
	logic [63:0]             gp_ll_s4 [3];
	logic [48:0]             gp_lh_s4 [3];
	logic [47:0]             gp_hl_s4 [3];
	logic [32:0]             gp_hh_s4 [3];
	logic [2:0]              cneg_s4;
	logic [CSQ_W-1:0]        csq_s5 [3];
	logic [PROD_W-1:0]       prod_s5 [3];
	logic [2:0]              cneg_s5;
	hold_t                   mid_s6;
	hold_t                   mid_s7;
	hold_t                   mid_s8;
	logic [63:0]             ps0_s9 [3];
	logic [63:0]             ps1_s9 [3];
	logic [64:0]             ps2_s9 [3];
	logic [CSQ_W-1:0]        cc_s9;
	logic [2:0]              cneg_s9;
	logic [NUM_W-1:0]        num_s10 [3];
	logic [DEN_W-1:0]        den_s10;
	logic                    ccz_s10;
	logic [2:0]              cneg_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1[0] <= $signed({pos.position_x[POS_W-1], pos.position_x})
				- $signed({origin_q[0][POS_W-1], origin_q[0]});
			op_s1[1] <= $signed({pos.position_y[POS_W-1], pos.position_y})
				- $signed({origin_q[1][POS_W-1], origin_q[1]});
			op_s1[2] <= $signed({pos.position_z[POS_W-1], pos.position_z})
				- $signed({origin_q[2][POS_W-1], origin_q[2]});

			dop_s2[0] <= d[1] * op_s1[2];
			dop_s2[1] <= d[2] * op_s1[1];
			dop_s2[2] <= d[2] * op_s1[0];
			dop_s2[3] <= d[0] * op_s1[2];
			dop_s2[4] <= d[0] * op_s1[1];
			dop_s2[5] <= d[1] * op_s1[0];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_comp
		logic signed [C_W-1:0] cabs;
		logic [16:0]           ch;
		logic [31:0]           cl;
		logic [15:0]           gh;
		logic [31:0]           gl;

		assign cv[i] = C_W'(dop_s2[2*i]) - C_W'(dop_s2[2*i+1]);
		assign cabs  = cv[i][C_W-1] ? -cv[i] : cv[i];
		assign ch    = cmag_s3[i][CMAG_W-1:32];
		assign cl    = cmag_s3[i][31:0];
		assign gh    = gain_abs[GAIN_W-1:32];
		assign gl    = gain_abs[31:0];

		always_ff @(posedge clk) begin
			if (en) begin
				cmag_s3[i] <= cabs[CMAG_W-1:0];
				cneg_s3[i] <= cv[i][C_W-1];

				sq_hh_s4[i] <= 34'(ch) * 34'(ch);
				sq_hl_s4[i] <= 49'(ch) * 49'(cl);
				sq_ll_s4[i] <= 64'(cl) * 64'(cl);
				gp_ll_s4[i] <= 64'(gl) * 64'(cl);
				gp_lh_s4[i] <= 49'(gl) * 49'(ch);
				gp_hl_s4[i] <= 48'(gh) * 48'(cl);
				gp_hh_s4[i] <= 33'(gh) * 33'(ch);
				cneg_s4[i]  <= cneg_s3[i];

				csq_s5[i]  <= CSQ_W'(sq_ll_s4[i]) + (CSQ_W'(sq_hl_s4[i]) << 33)
					+ (CSQ_W'(sq_hh_s4[i]) << 64);
				prod_s5[i] <= PROD_W'(gp_ll_s4[i]) + (PROD_W'(gp_lh_s4[i]) << 32)
					+ (PROD_W'(gp_hl_s4[i]) << 32) + (PROD_W'(gp_hh_s4[i]) << 64);
				cneg_s5[i] <= cneg_s4[i];

				ps0_s9[i] <= 64'(mid_s8.prod[i][31:0]) * 64'(sq_root_q[SQ_STG-1]);
				ps1_s9[i] <= 64'(mid_s8.prod[i][63:32]) * 64'(sq_root_q[SQ_STG-1]);
				ps2_s9[i] <= 65'(mid_s8.prod[i][PROD_W-1:64]) * 65'(sq_root_q[SQ_STG-1]);

				num_s10[i] <= NUM_W'(ps0_s9[i]) + (NUM_W'(ps1_s9[i]) << 32)
					+ (NUM_W'(ps2_s9[i]) << 64);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s6.prod <= {prod_s5[2], prod_s5[1], prod_s5[0]};
			mid_s6.cc   <= csq_s5[0] + csq_s5[1] + csq_s5[2];
			mid_s6.cneg <= cneg_s5;
			mid_s7      <= mid_s6;
			mid_s8      <= mid_s7;
			cc_s9       <= mid_s8.cc;
			cneg_s9     <= mid_s8.cneg;
			den_s10     <= {cc_s9, 16'b0};
			ccz_s10     <= cc_s9 == '0;
			cneg_s10    <= cneg_s9;
		end
	end

	logic [QUO_W-1:0] quo_d [3];
	logic [DEN_W-1:0] rem_d [3];
	logic [DEN_W-1:0] den_d [3];
	logic             big_d [3];
	logic [2:0]       cneg_sd [QUO_W];
	logic             ccz_sd [QUO_W];

	for (genvar i = 0; i < 3; i++) begin : g_div
		swmf_div u_div (
			.clk     (clk),
			.en      (en),
			.num     (num_s10[i]),
			.den     (den_s10),
			.quo     (quo_d[i]),
			.rem     (rem_d[i]),
			.den_out (den_d[i]),
			.big     (big_d[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cneg_sd[0] <= cneg_s10;
			ccz_sd[0]  <= ccz_s10;
			for (int k = 1; k < QUO_W; k++) begin
				cneg_sd[k] <= cneg_sd[k-1];
				ccz_sd[k]  <= ccz_sd[k-1];
			end
		end
	end

	logic [FIELD_W-1:0] fval [3];
	logic               any_sat;
	logic [FIELD_W-1:0] fx_q;
	logic [FIELD_W-1:0] fy_q;
	logic [FIELD_W-1:0] fz_q;
	status_t            status_q;

	always_comb begin
		logic             rnd;
		logic [QR_W-1:0]  qr;
		logic             neg;
		logic             sat;
		logic [FIELD_W-1:0] mag;
		any_sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rnd = {rem_d[i], 1'b0} >= {1'b0, den_d[i]};
			qr  = {1'b0, quo_d[i]} + QR_W'(rnd);
			neg = gain_q[GAIN_W-1] ^ cneg_sd[QUO_W-1][i];
			if (neg) begin
				sat = big_d[i] | (qr > MAG_NEG_MAX);
				mag = sat ? FIELD_W'(MAG_NEG_MAX) : qr[FIELD_W-1:0];
				fval[i] = FIELD_W'(~mag + 1'b1);
			end else begin
				sat = big_d[i] | (qr > MAG_POS_MAX);
				mag = sat ? FIELD_W'(MAG_POS_MAX) : qr[FIELD_W-1:0];
				fval[i] = mag;
			end
			any_sat = any_sat | sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dir_zero) begin
				fx_q     <= '0;
				fy_q     <= '0;
				fz_q     <= '0;
				status_q <= ST_DIR_ZERO;
			end else if (ccz_sd[QUO_W-1]) begin
				fx_q     <= '0;
				fy_q     <= '0;
				fz_q     <= '0;
				status_q <= ST_ON_WIRE;
			end else begin
				fx_q     <= fval[0];
				fy_q     <= fval[1];
				fz_q     <= fval[2];
				status_q <= any_sat ? ST_SATURATED : ST_OK;
			end
		end
	end

	assign field.field_x = fx_q;
	assign field.field_y = fy_q;
	assign field.field_z = fz_q;
	assign field.status  = status_q;

endmodule
